### src/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the six-byte utf-8 stream decoder
// no dependencies; imported by utf8_stream_decoder_core

package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned LEN_W  = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [LEN_W-1:0]  len_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_STRAY   = 2'd1,
    ST_BADCONT = 2'd2,
    ST_BADLEAD = 2'd3
  } status_t;

  // byte classes and payload masks
  localparam byte_t CONT_MASK  = 8'hC0;
  localparam byte_t CONT_TAG   = 8'h80;
  localparam byte_t CONT_BITS  = 8'h3F;
  localparam byte_t LEAD2_BASE = 8'hC0;
  localparam byte_t LEAD3_BASE = 8'hE0;
  localparam byte_t LEAD4_BASE = 8'hF0;
  localparam byte_t LEAD5_BASE = 8'hF8;
  localparam byte_t LEAD6_BASE = 8'hFC;
  localparam byte_t BADLEAD_LO = 8'hFE;

  localparam len_t LEN_NONE = 3'd0;
  localparam len_t LEN_ONE  = 3'd1;

endpackage

### src/utf8_stream_decoder_core.sv
// utf8_stream_decoder_core: decodes the original 1..6 byte utf-8 form into code points
// depends on utf8d_pkg (types, status codes, byte masks)
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  in_     | in        | in_valid/in_stall  | in_byte_in[7:0]
//  out_    | out       | out_valid/out_stall| out_code_point[30:0], out_seq_len, out_status
//
// one byte is taken per cycle while in_stall is low; a result passes through the input register,
// then is decoded into the result register
// throughput is set by the single decode step between the byte register and result register
// in_stall rises only while a result sits in the output register and out_stall holds it
// rst_n is synchronous, active low; it empties both registers and closes any open sequence

module utf8_stream_decoder_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  utf8d_pkg::byte_t      in_byte_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output utf8d_pkg::cp_t        out_code_point,
  output utf8d_pkg::len_t       out_seq_len,
  output utf8d_pkg::status_t    out_status
);
  import utf8d_pkg::*;

  // input register
  logic    s1_valid_r, s1_valid_nxt;
  byte_t   s1_byte_r;

  // decoder state
  len_t    bytes_left_r, bytes_left_nxt;
  len_t    total_len_r, total_len_nxt;
  cp_t     partial_r, partial_nxt;

  // result register
  logic    out_valid_r, out_valid_nxt;
  cp_t     out_cp_r, out_cp_nxt;
  len_t    out_len_r, out_len_nxt;
  status_t out_st_r, out_st_nxt;

  // decode results for the byte in s1
  logic    emit;
  cp_t     emit_cp;
  len_t    emit_len;
  status_t emit_st;
  logic    advance;
  cp_t     shifted;

  // the pipeline moves unless a finished result is held by the sink
  assign advance  = !(out_valid_r && out_stall);
  // the input register only loads while the pipeline moves
  assign in_stall = !advance;

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;
  assign out_seq_len    = out_len_r;
  assign out_status     = out_st_r;

  // append six payload bits; the top bits fall off at 31
  assign shifted = {partial_r[CP_W-7:0], s1_byte_r[5:0]};

  // single decode step
  always_comb begin
    emit           = 1'b0;
    emit_cp        = '0;
    emit_len       = LEN_NONE;
    emit_st        = ST_OK;
    bytes_left_nxt = bytes_left_r;
    total_len_nxt  = total_len_r;
    partial_nxt    = partial_r;
    if (bytes_left_r != LEN_NONE) begin
      if ((s1_byte_r & CONT_MASK) != CONT_TAG) begin
        // bad continuation: drop the partial sequence and this byte
        emit           = 1'b1;
        emit_st        = ST_BADCONT;
        bytes_left_nxt = LEN_NONE;
        total_len_nxt  = LEN_NONE;
        partial_nxt    = '0;
      end else if (bytes_left_r == LEN_ONE) begin
        // final continuation completes the sequence
        emit           = 1'b1;
        emit_cp        = shifted;
        emit_len       = total_len_r;
        bytes_left_nxt = LEN_NONE;
        total_len_nxt  = LEN_NONE;
        partial_nxt    = '0;
      end else begin
        bytes_left_nxt = bytes_left_r - LEN_ONE;
        partial_nxt    = shifted;
      end
    end else if (s1_byte_r < CONT_TAG) begin
      // plain ascii
      emit     = 1'b1;
      emit_cp  = cp_t'(s1_byte_r);
      emit_len = LEN_ONE;
    end else if (s1_byte_r < LEAD2_BASE) begin
      emit    = 1'b1;
      emit_st = ST_STRAY;
    end else if (s1_byte_r >= BADLEAD_LO) begin
      emit    = 1'b1;
      emit_st = ST_BADLEAD;
    end else begin
      // lead byte opens a sequence
      if (s1_byte_r < LEAD3_BASE) begin
        total_len_nxt = 3'd2;
        partial_nxt   = cp_t'(s1_byte_r[4:0]);
      end else if (s1_byte_r < LEAD4_BASE) begin
        total_len_nxt = 3'd3;
        partial_nxt   = cp_t'(s1_byte_r[3:0]);
      end else if (s1_byte_r < LEAD5_BASE) begin
        total_len_nxt = 3'd4;
        partial_nxt   = cp_t'(s1_byte_r[2:0]);
      end else if (s1_byte_r < LEAD6_BASE) begin
        total_len_nxt = 3'd5;
        partial_nxt   = cp_t'(s1_byte_r[1:0]);
      end else begin
        total_len_nxt = 3'd6;
        partial_nxt   = cp_t'(s1_byte_r[0]);
      end
      bytes_left_nxt = total_len_nxt - LEN_ONE;
    end
  end

  // register next values
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_cp_nxt    = out_cp_r;
    out_len_nxt   = out_len_r;
    out_st_nxt    = out_st_r;
    if (advance) begin
      s1_valid_nxt  = in_valid;
      out_valid_nxt = s1_valid_r && emit;
      out_cp_nxt    = emit_cp;
      out_len_nxt   = emit_len;
      out_st_nxt    = emit_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      bytes_left_r <= LEN_NONE;
      total_len_r  <= LEN_NONE;
      partial_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance && s1_valid_r) begin
        bytes_left_r <= bytes_left_nxt;
        total_len_r  <= total_len_nxt;
        partial_r    <= partial_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_byte_r <= in_byte_in;
      out_cp_r  <= out_cp_nxt;
      out_len_r <= out_len_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  // open sequence always has fewer bytes outstanding than its length
  a_left_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r != LEN_NONE |-> bytes_left_r < total_len_r)
    else $error("bytes_left not below total_len");

  // an ok result always carries a length
  a_ok_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r == ST_OK |-> out_len_r != LEN_NONE)
    else $error("ok result with zero length");

  // error results carry neither value nor length
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r != ST_OK |-> out_cp_r == '0 && out_len_r == LEN_NONE)
    else $error("error result with payload");

  // input side only backs off while the result register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a held result");

endmodule
